// File: design/lwfc_pkg.sv
package lwfc_pkg;

   localparam int MaxSamples = 4096;
   localparam int CntW       = $clog2(MaxSamples + 1);
   localparam int RangeW     = 16;
   localparam int AngleW     = 14;
   localparam int StepW      = 13;
   localparam int HalfW      = 12;
   localparam int GainW      = 16;
   localparam int LimitW     = 16;
   localparam int SpeedW     = 17;
   localparam int DistSumW   = RangeW + $clog2(MaxSamples);
   localparam int AngSumW    = AngleW + $clog2(MaxSamples) + 1;
   localparam int DivW       = DistSumW;
   localparam int ErrW       = RangeW + 1;
   localparam int ProdW      = 2 * ErrW;
   localparam int GainShift  = 8;
   localparam int Deadband   = 30;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 16;

   typedef enum logic [CsrIndexW-1:0] {
      RegTargetDistance = 3'd0,
      RegDetectLimit    = 3'd1,
      RegWindowHalf     = 3'd2,
      RegGainLinear     = 3'd3,
      RegGainAngular    = 3'd4,
      RegLinearLimit    = 3'd5,
      RegAngularLimit   = 3'd6,
      RegMinPoints      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [RangeW-1:0] target_distance_mm;
      logic [RangeW-1:0] detect_limit_mm;
      logic [HalfW-1:0]  window_half_mrad;
      logic [GainW-1:0]  gain_linear_q8;
      logic [GainW-1:0]  gain_angular_q8;
      logic [LimitW-1:0] linear_limit;
      logic [LimitW-1:0] angular_limit;
      logic [CntW-1:0]   min_points;
   } cfg_type;

   typedef struct packed {
      logic accum;
      logic latch_stop;
      logic div_start;
      logic div_sel_angle;
      logic capture_dist;
      logic capture_angle;
      logic mul_en;
      logic mul_angle;
      logic scale_en;
      logic scale_angle;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic stop_cond;
      logic div_done;
   } status_type;

endpackage

// File: design/lwfc_req_if.sv
interface lwfc_req_if import lwfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [RangeW-1:0]        range_mm;
   logic                     range_finite;
   logic                     has_sample;
   logic signed [AngleW-1:0] angle_mrad;
   logic [StepW-1:0]         angle_step_mrad;
   logic [RangeW-1:0]        sensor_min_mm;
   logic [RangeW-1:0]        sensor_max_mm;
   logic                     last;

   modport source (
      output valid, range_mm, range_finite, has_sample, angle_mrad, angle_step_mrad,
             sensor_min_mm, sensor_max_mm, last,
      input  ready
   );

   modport sink (
      input  valid, range_mm, range_finite, has_sample, angle_mrad, angle_step_mrad,
             sensor_min_mm, sensor_max_mm, last,
      output ready
   );
endinterface

// File: design/lwfc_rsp_if.sv
interface lwfc_rsp_if import lwfc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SpeedW-1:0] linear_speed;
   logic signed [SpeedW-1:0] angular_speed;
   logic                     stopped;
   logic [CntW-1:0]          points_used;

   modport source (
      output valid, linear_speed, angular_speed, stopped, points_used,
      input  ready
   );

   modport sink (
      input  valid, linear_speed, angular_speed, stopped, points_used,
      output ready
   );
endinterface

// File: design/lwfc_csr.sv
module lwfc_csr import lwfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_distance_mm <= RangeW'(1000);
         cfg_ff.detect_limit_mm    <= RangeW'(2000);
         cfg_ff.window_half_mrad   <= HalfW'(349);
         cfg_ff.gain_linear_q8     <= GainW'(205);
         cfg_ff.gain_angular_q8    <= GainW'(461);
         cfg_ff.linear_limit       <= LimitW'(350);
         cfg_ff.angular_limit      <= LimitW'(1200);
         cfg_ff.min_points         <= CntW'(8);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            RegTargetDistance: cfg_ff.target_distance_mm <= csr_data[RangeW-1:0];
            RegDetectLimit:    cfg_ff.detect_limit_mm    <= csr_data[RangeW-1:0];
            RegWindowHalf:     cfg_ff.window_half_mrad   <= csr_data[HalfW-1:0];
            RegGainLinear:     cfg_ff.gain_linear_q8     <= csr_data[GainW-1:0];
            RegGainAngular:    cfg_ff.gain_angular_q8    <= csr_data[GainW-1:0];
            RegLinearLimit:    cfg_ff.linear_limit       <= csr_data[LimitW-1:0];
            RegAngularLimit:   cfg_ff.angular_limit      <= csr_data[LimitW-1:0];
            RegMinPoints:      cfg_ff.min_points         <= csr_data[CntW-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/lwfc_div.sv
module lwfc_div import lwfc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DivW-1:0] dividend,
   input  logic [CntW-1:0] divisor,
   output logic            busy,
   output logic [DivW-1:0] quotient
);

   localparam int IterW = $clog2(DivW);

   logic [CntW-1:0]  rem_ff, rem_in;
   logic [DivW-1:0]  quo_ff, quo_in;
   logic [IterW-1:0] iter_ff;
   logic             busy_ff;
   logic [CntW:0]    shifted;
   logic [CntW:0]    diff;
   logic             fits;

   // Restoring division, one quotient bit per cycle, most significant first.
   always_comb begin
      shifted = {rem_ff, quo_ff[DivW-1]};
      diff    = shifted - {1'b0, divisor};
      fits    = shifted >= {1'b0, divisor};
      rem_in  = fits ? diff[CntW-1:0] : shifted[CntW-1:0];
      quo_in  = {quo_ff[DivW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= '0;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + IterW'(1);
         if (iter_ff == IterW'(DivW - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: design/lwfc_datapath.sv
module lwfc_datapath import lwfc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  cmd_type                  cmd,
   input  logic [RangeW-1:0]        range_mm,
   input  logic                     range_finite,
   input  logic                     has_sample,
   input  logic signed [AngleW-1:0] angle_mrad,
   input  logic [StepW-1:0]         angle_step_mrad,
   input  logic [RangeW-1:0]        sensor_min_mm,
   input  logic [RangeW-1:0]        sensor_max_mm,
   output status_type               status,
   output logic signed [SpeedW-1:0] linear_speed,
   output logic signed [SpeedW-1:0] angular_speed,
   output logic                     stopped,
   output logic [CntW-1:0]          points_used
);

   localparam int WinW = AngleW + 1;
   localparam logic signed [ErrW-1:0]  DbLimit = ErrW'(Deadband);
   localparam logic signed [ProdW-1:0] RoundAdj = ProdW'((1 << GainShift) - 1);

   logic signed [AngSumW-1:0] angle_sum_ff, angle_sum_in;
   logic [DistSumW-1:0]       dist_sum_ff, dist_sum_in;
   logic [CntW-1:0]           cnt_ff, cnt_in;
   logic                      step_bad_ff, step_bad_in;
   logic                      stop_ff;

   logic signed [ErrW-1:0]    err_ff, err_in;
   logic signed [AngleW-1:0]  avg_a_ff, avg_a_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [SpeedW-1:0]  lin_ff, ang_ff, speed_in;

   logic signed [SpeedW-1:0]  out_lin_ff, out_ang_ff;
   logic                      out_stop_ff;
   logic [CntW-1:0]           out_cnt_ff;

   logic [StepW:0]            win_edge;
   logic signed [WinW-1:0]    edge_s, angle_x;
   logic                      in_win, in_rng, take;
   logic [AngSumW-1:0]        angle_mag;
   logic [DivW-1:0]           dividend;
   logic [DivW-1:0]           quotient;
   logic                      div_busy;
   logic [AngleW-1:0]         avg_a_mag;
   logic signed [ErrW-1:0]    mul_a, mul_b;
   logic signed [ProdW-1:0]   adj, scaled, lim_s, clamped;
   logic                      in_db;

   // Sample qualification and accumulation.
   always_comb begin
      win_edge = (StepW+1)'(cfg.window_half_mrad) + (StepW+1)'(angle_step_mrad);
      edge_s   = $signed({1'b0, win_edge});
      angle_x  = WinW'(angle_mrad);
      in_win   = (angle_x > -edge_s) && (angle_x < edge_s);
      in_rng   = (range_mm >= sensor_min_mm) && (range_mm <= sensor_max_mm) &&
                 (range_mm <= cfg.detect_limit_mm);
      take     = has_sample && range_finite && in_win && in_rng &&
                 (cnt_ff < CntW'(MaxSamples));

      angle_sum_in = angle_sum_ff;
      dist_sum_in  = dist_sum_ff;
      cnt_in       = cnt_ff;
      step_bad_in  = step_bad_ff;
      if (cmd.load_out) begin
         angle_sum_in = '0;
         dist_sum_in  = '0;
         cnt_in       = '0;
         step_bad_in  = 1'b0;
      end else if (cmd.accum) begin
         if (angle_step_mrad == '0) begin
            step_bad_in = 1'b1;
         end
         if (take) begin
            angle_sum_in = angle_sum_ff + AngSumW'(angle_mrad);
            dist_sum_in  = dist_sum_ff + DistSumW'(range_mm);
            cnt_in       = cnt_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_sum_ff <= '0;
         dist_sum_ff  <= '0;
         cnt_ff       <= '0;
         step_bad_ff  <= 1'b0;
      end else begin
         angle_sum_ff <= angle_sum_in;
         dist_sum_ff  <= dist_sum_in;
         cnt_ff       <= cnt_in;
         step_bad_ff  <= step_bad_in;
      end
   end

   assign status.stop_cond = step_bad_ff || (cnt_ff == '0) || (cnt_ff < cfg.min_points);
   assign status.div_done  = !div_busy;

   // The divider works on magnitudes; the bearing sign is put back afterwards.
   assign angle_mag = angle_sum_ff[AngSumW-1] ? AngSumW'(-angle_sum_ff) : angle_sum_ff;
   assign dividend  = cmd.div_sel_angle ? DivW'(angle_mag) : dist_sum_ff;

   lwfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      err_in    = $signed({1'b0, quotient[RangeW-1:0]}) -
                  $signed({1'b0, cfg.target_distance_mm});
      avg_a_mag = quotient[AngleW-1:0];
      avg_a_in  = angle_sum_ff[AngSumW-1] ? -$signed(avg_a_mag) : $signed(avg_a_mag);

      mul_a   = $signed({1'b0, cmd.mul_angle ? cfg.gain_angular_q8 : cfg.gain_linear_q8});
      mul_b   = cmd.mul_angle ? ErrW'(avg_a_ff) : err_ff;
      prod_in = mul_a * mul_b;

      // Shift toward zero, then clamp and apply the deadband.
      adj     = prod_ff[ProdW-1] ? prod_ff + RoundAdj : prod_ff;
      scaled  = adj >>> GainShift;
      lim_s   = $signed(ProdW'(cmd.scale_angle ? cfg.angular_limit : cfg.linear_limit));
      if (scaled > lim_s) begin
         clamped = lim_s;
      end else if (scaled < -lim_s) begin
         clamped = -lim_s;
      end else begin
         clamped = scaled;
      end
      if (cmd.scale_angle) begin
         in_db = (ErrW'(avg_a_ff) > -DbLimit) && (ErrW'(avg_a_ff) < DbLimit);
      end else begin
         in_db = (err_ff > -DbLimit) && (err_ff < DbLimit);
      end
      speed_in = in_db ? '0 : clamped[SpeedW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_stop) begin
         stop_ff <= status.stop_cond;
      end
      if (cmd.capture_dist) begin
         err_ff <= err_in;
      end
      if (cmd.capture_angle) begin
         avg_a_ff <= avg_a_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.scale_en) begin
         if (cmd.scale_angle) begin
            ang_ff <= speed_in;
         end else begin
            lin_ff <= speed_in;
         end
      end
      if (cmd.load_out) begin
         out_lin_ff  <= stop_ff ? '0 : lin_ff;
         out_ang_ff  <= stop_ff ? '0 : ang_ff;
         out_stop_ff <= stop_ff;
         out_cnt_ff  <= cnt_ff;
      end
   end

   assign linear_speed  = out_lin_ff;
   assign angular_speed = out_ang_ff;
   assign stopped       = out_stop_ff;
   assign points_used   = out_cnt_ff;

endmodule

// File: design/lwfc_ctrl.sv
module lwfc_ctrl import lwfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  logic       rsp_ready,
   input  status_type status,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      StAccum,
      StCheck,
      StDivDist,
      StDivAngle,
      StMulLin,
      StScaleLin,
      StMulAng,
      StScaleAng,
      StFinish
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;
   logic      accept;
   logic      out_free;

   always_comb begin
      req_ready = (state_ff == StAccum);
      accept    = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      cmd       = '0;
      state_in  = state_ff;
      case (state_ff)
         StAccum: begin
            cmd.accum = accept;
            if (accept && req_last) begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            cmd.latch_stop = 1'b1;
            if (status.stop_cond) begin
               state_in = StFinish;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = StDivDist;
            end
         end
         StDivDist: begin
            if (status.div_done) begin
               cmd.capture_dist  = 1'b1;
               cmd.div_start     = 1'b1;
               cmd.div_sel_angle = 1'b1;
               state_in          = StDivAngle;
            end
         end
         StDivAngle: begin
            if (status.div_done) begin
               cmd.capture_angle = 1'b1;
               state_in          = StMulLin;
            end
         end
         StMulLin: begin
            cmd.mul_en = 1'b1;
            state_in   = StScaleLin;
         end
         StScaleLin: begin
            cmd.scale_en = 1'b1;
            state_in     = StMulAng;
         end
         StMulAng: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_angle = 1'b1;
            state_in      = StScaleAng;
         end
         StScaleAng: begin
            cmd.scale_en    = 1'b1;
            cmd.scale_angle = 1'b1;
            state_in        = StFinish;
         end
         StFinish: begin
            // Wait here until the output register can take the new result.
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = StAccum;
            end
         end
         default: begin
            state_in = StAccum;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StAccum;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/lidar_window_follow_controller.sv
// Samples that do not close a scan are taken one request per cycle.
// The closing request gives its result once the shared divider, one quotient bit per cycle
// over 28 bits, has run once for the range average and once for the bearing average; a
// scan that ends in a forced stop skips the divider and goes straight to the output.
// A new scan may start while the previous result waits in the output register.
// Synchronous reset restores the register defaults, clears the sums and drops any result.
module lidar_window_follow_controller import lwfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   lwfc_req_if.sink             req_chan,
   lwfc_rsp_if.source           rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   lwfc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   lwfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lwfc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .range_mm        (req_chan.range_mm),
      .range_finite    (req_chan.range_finite),
      .has_sample      (req_chan.has_sample),
      .angle_mrad      (req_chan.angle_mrad),
      .angle_step_mrad (req_chan.angle_step_mrad),
      .sensor_min_mm   (req_chan.sensor_min_mm),
      .sensor_max_mm   (req_chan.sensor_max_mm),
      .status          (status),
      .linear_speed    (rsp_chan.linear_speed),
      .angular_speed   (rsp_chan.angular_speed),
      .stopped         (rsp_chan.stopped),
      .points_used     (rsp_chan.points_used)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // Once a scan is closed, no further request is taken until its result is built.
   a_close_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last) |=> !req_chan.ready)
      else $error("request accepted right after a scan was closed");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.stopped) |->
         (rsp_chan.linear_speed == '0 && rsp_chan.angular_speed == '0))
      else $error("forced stop carries a nonzero speed");

   a_move_has_points: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.stopped) |-> (rsp_chan.points_used != '0))
      else $error("motion command issued from an empty scan");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !req_chan.ready)
      else $error("request taken while the divider starts");

endmodule
